// ===== rtl/sda_pkg.sv =====
package sda_pkg;

    localparam int WORK_W    = 128;
    localparam int DCNT_W    = $clog2(WORK_W);
    localparam int D10_W     = 8;
    localparam logic [4:0] QD_RESET = 5'd12;
    localparam logic [4:0] QD_MAX   = 5'd18;
    localparam logic [4:0] POW_TOP  = 5'd19;
    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TEN     = 64'd10;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TRIM_A, ST_TRIM_A_R, ST_TRIM_B, ST_TRIM_B_R, ST_DISPATCH,
        ST_ALIGN, ST_ADDSUB, ST_MUL, ST_DIV, ST_DIV10, ST_QUOT, ST_DCOUNT, ST_DTRUNC,
        ST_DTRUNC_R, ST_DSTEP, ST_DSTEP_R, ST_NEGSC, ST_STRIP, ST_STRIP_R,
        ST_CHK63, ST_TRUNC63, ST_TRUNC63_R, ST_FINAL
    } t_state;

    function automatic logic [WORK_W+3:0] mul10(input logic [WORK_W-1:0] x);
        mul10 = {x, 3'b000} + {2'b00, x, 1'b0};
    endfunction

    function automatic logic [63:0] pow10(input logic [4:0] k);
        unique case (k)
            5'd0:  pow10 = 64'd1;
            5'd1:  pow10 = 64'd10;
            5'd2:  pow10 = 64'd100;
            5'd3:  pow10 = 64'd1000;
            5'd4:  pow10 = 64'd10000;
            5'd5:  pow10 = 64'd100000;
            5'd6:  pow10 = 64'd1000000;
            5'd7:  pow10 = 64'd10000000;
            5'd8:  pow10 = 64'd100000000;
            5'd9:  pow10 = 64'd1000000000;
            5'd10: pow10 = 64'd10000000000;
            5'd11: pow10 = 64'd100000000000;
            5'd12: pow10 = 64'd1000000000000;
            5'd13: pow10 = 64'd10000000000000;
            5'd14: pow10 = 64'd100000000000000;
            5'd15: pow10 = 64'd1000000000000000;
            5'd16: pow10 = 64'd10000000000000000;
            5'd17: pow10 = 64'd100000000000000000;
            5'd18: pow10 = 64'd1000000000000000000;
            5'd19: pow10 = 64'd10000000000000000000;
            default: pow10 = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

endpackage

// ===== rtl/sda_in_if.sv =====
interface sda_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [63:0] mantissa_a;
    logic [5:0]         scale_a;
    logic signed [63:0] mantissa_b;
    logic [5:0]         scale_b;

    modport source (output valid, kind, mantissa_a, scale_a, mantissa_b, scale_b,
                    input ready);
    modport sink   (input valid, kind, mantissa_a, scale_a, mantissa_b, scale_b,
                    output ready);
endinterface

// ===== rtl/sda_out_if.sv =====
interface sda_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] mantissa_out;
    logic [5:0]         scale_out;
    logic               overflow;
    logic               divide_by_zero;

    modport source (output valid, mantissa_out, scale_out, overflow, divide_by_zero,
                    input ready);
    modport sink   (input valid, mantissa_out, scale_out, overflow, divide_by_zero,
                    output ready);
endinterface

// ===== rtl/scaled_decimal_arithmetic_unit.sv =====
// Scaled decimal add, subtract, multiply and divide on mantissa/scale pairs.
// One transaction is worked at a time; the input is not ready until the
// result has been placed in the output register, which then waits for the
// sink while the next transaction may already be taken. A small sequencer
// reuses a few shared units: a restoring divider giving one quotient bit per
// cycle (for the integer quotient and for each further quotient digit), a
// divide-by-ten unit taking eight dividend bits per cycle (for each trailing
// zero stripped and each digit truncated) and a shift-add multiplier taking
// one bit per cycle. No clearing pass after reset.
module scaled_decimal_arithmetic_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sda_in_if.sink       i_req,
    sda_out_if.source    o_rsp,
    input  logic         i_cfg_we,
    input  logic [4:0]   i_cfg_data
);

    localparam int W = sda_pkg::WORK_W;

    sda_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [1:0]   r_kind, n_kind;
    logic [63:0]  r_a, n_a, r_b, n_b, r_r, n_r;
    logic [5:0]   r_sa, n_sa, r_sb, n_sb, r_d, n_d;
    logic         r_na, n_na, r_nb, n_nb, r_nx, n_nx, r_ny, n_ny, r_neg, n_neg;
    logic [W-1:0] r_x, n_x, r_y, n_y, r_dq, n_dq;
    logic [8:0]   r_sc, n_sc;
    logic         r_regovf, n_regovf, r_ovf, n_ovf, r_phase, n_phase, r_dz, n_dz;
    logic [4:0]   r_cnt, n_cnt;
    logic [6:0]   r_k, n_k;
    logic [63:0]  r_dd, n_dd, r_dr, n_dr;
    logic [sda_pkg::DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [4:0]   r_qd;

    logic         r_ov, n_ov, r_oovf, n_oovf, r_odz, n_odz;
    logic [63:0]  r_om, n_om;
    logic [5:0]   r_os, n_os;

    logic [64:0]    rem2, rsub;
    logic           ge;
    logic [4:0]     qd;
    logic [W+3:0]   m10x, m10y, m10r;
    logic [W:0]     sum;
    logic [W+1:0]   macc;
    logic [W-1:0]   xstep;
    logic [63:0]    lim;
    logic           big;
    logic [3:0]     d10r;
    logic [4:0]     d10t;
    logic [sda_pkg::D10_W-1:0] d10q;

    assign i_req.ready          = (r_state == sda_pkg::ST_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.mantissa_out   = $signed(r_om);
    assign o_rsp.scale_out      = r_os;
    assign o_rsp.overflow       = r_oovf;
    assign o_rsp.divide_by_zero = r_odz;

    always_comb begin
        rem2  = {r_dr, r_dq[W-1]};
        ge    = (rem2 >= {1'b0, r_dd});
        rsub  = rem2 - {1'b0, r_dd};
        qd    = (r_qd == 5'd0) ? 5'd1 : ((r_qd > sda_pkg::QD_MAX) ? sda_pkg::QD_MAX : r_qd);
        m10x  = sda_pkg::mul10(r_x);
        m10y  = sda_pkg::mul10(r_y);
        m10r  = sda_pkg::mul10(W'(r_r));
        sum   = {1'b0, r_x} + {1'b0, r_y};
        macc  = {1'b0, r_x, 1'b0} + {2'b00, {(W-64){1'b0}}, (r_b[63] ? r_a : 64'd0)};
        xstep = m10x[W-1:0] + r_dq;
        lim   = r_neg ? sda_pkg::SAT_NEG : sda_pkg::SAT_POS;
        big   = (|r_x[W-1:64]) || (r_x[63:0] > lim);
        // divide by ten, several dividend bits per cycle
        d10r  = r_dr[3:0];
        d10t  = '0;
        d10q  = '0;
        for (int i = 0; i < sda_pkg::D10_W; i++) begin
            d10t = {d10r, r_dq[W-1-i]};
            if (d10t >= 5'd10) begin
                d10q[sda_pkg::D10_W-1-i] = 1'b1;
                d10r = 4'(d10t - 5'd10);
            end else begin
                d10r = d10t[3:0];
            end
        end
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_kind = r_kind;
        n_a = r_a; n_b = r_b; n_r = r_r; n_sa = r_sa; n_sb = r_sb; n_d = r_d;
        n_na = r_na; n_nb = r_nb; n_nx = r_nx; n_ny = r_ny; n_neg = r_neg;
        n_x = r_x; n_y = r_y; n_dq = r_dq; n_sc = r_sc;
        n_regovf = r_regovf; n_ovf = r_ovf; n_phase = r_phase; n_dz = r_dz;
        n_cnt = r_cnt; n_k = r_k; n_dd = r_dd; n_dr = r_dr; n_dcnt = r_dcnt;
        n_ov = r_ov; n_oovf = r_oovf; n_odz = r_odz; n_om = r_om; n_os = r_os;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            sda_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = i_req.kind;
                    n_na     = i_req.mantissa_a[63];
                    n_nb     = i_req.mantissa_b[63];
                    n_a      = i_req.mantissa_a[63] ? (64'd0 - $unsigned(i_req.mantissa_a))
                                                    : $unsigned(i_req.mantissa_a);
                    n_b      = i_req.mantissa_b[63] ? (64'd0 - $unsigned(i_req.mantissa_b))
                                                    : $unsigned(i_req.mantissa_b);
                    n_sa     = i_req.scale_a;
                    n_sb     = i_req.scale_b;
                    n_regovf = 1'b0;
                    n_ovf    = 1'b0;
                    n_phase  = 1'b0;
                    n_dz     = 1'b0;
                    n_state  = sda_pkg::ST_TRIM_A;
                end
            end
            sda_pkg::ST_TRIM_A: begin
                if (r_sa != 6'd0 && r_a != 64'd0) begin
                    n_dq = W'(r_a); n_dd = sda_pkg::TEN; n_dr = '0; n_dcnt = '0;
                    n_ret = sda_pkg::ST_TRIM_A_R; n_state = sda_pkg::ST_DIV10;
                end else begin
                    if (r_a == 64'd0) n_sa = 6'd0;
                    n_state = sda_pkg::ST_TRIM_B;
                end
            end
            sda_pkg::ST_TRIM_A_R: begin
                if (r_dr == 64'd0) begin
                    n_a = r_dq[63:0]; n_sa = r_sa - 6'd1; n_state = sda_pkg::ST_TRIM_A;
                end else begin
                    n_state = sda_pkg::ST_TRIM_B;
                end
            end
            sda_pkg::ST_TRIM_B: begin
                if (r_sb != 6'd0 && r_b != 64'd0) begin
                    n_dq = W'(r_b); n_dd = sda_pkg::TEN; n_dr = '0; n_dcnt = '0;
                    n_ret = sda_pkg::ST_TRIM_B_R; n_state = sda_pkg::ST_DIV10;
                end else begin
                    if (r_b == 64'd0) n_sb = 6'd0;
                    n_state = sda_pkg::ST_DISPATCH;
                end
            end
            sda_pkg::ST_TRIM_B_R: begin
                if (r_dr == 64'd0) begin
                    n_b = r_dq[63:0]; n_sb = r_sb - 6'd1; n_state = sda_pkg::ST_TRIM_B;
                end else begin
                    n_state = sda_pkg::ST_DISPATCH;
                end
            end
            sda_pkg::ST_DISPATCH: begin
                unique case (r_kind)
                    sda_pkg::KIND_ADD, sda_pkg::KIND_SUB: begin
                        if (r_sa >= r_sb) begin
                            n_x = W'(r_a); n_y = W'(r_b); n_nx = r_na;
                            n_ny = r_nb ^ (r_kind == sda_pkg::KIND_SUB);
                            n_d = r_sa - r_sb; n_sc = 9'(r_sa);
                        end else begin
                            n_x = W'(r_b); n_y = W'(r_a); n_ny = r_na;
                            n_nx = r_nb ^ (r_kind == sda_pkg::KIND_SUB);
                            n_d = r_sb - r_sa; n_sc = 9'(r_sb);
                        end
                        n_state = sda_pkg::ST_ALIGN;
                    end
                    sda_pkg::KIND_MUL: begin
                        n_x = '0; n_k = 7'd0; n_sc = 9'(r_sa) + 9'(r_sb);
                        n_neg = r_na ^ r_nb; n_state = sda_pkg::ST_MUL;
                    end
                    default: begin
                        n_sc = 9'(r_sa) - 9'(r_sb);
                        n_neg = r_na ^ r_nb;
                        if (r_b == 64'd0) begin
                            n_dz = 1'b1; n_state = sda_pkg::ST_FINAL;
                        end else if (r_a == 64'd0) begin
                            n_x = '0; n_sc = 9'd0; n_neg = 1'b0; n_state = sda_pkg::ST_FINAL;
                        end else begin
                            n_dq = W'(r_a); n_dd = r_b; n_dr = '0; n_dcnt = '0;
                            n_ret = sda_pkg::ST_QUOT; n_state = sda_pkg::ST_DIV;
                        end
                    end
                endcase
            end
            sda_pkg::ST_ALIGN: begin
                if (r_d != 6'd0) begin
                    if (m10y[W+3:W] != 4'd0) begin
                        n_neg = r_ny; n_regovf = 1'b1; n_state = sda_pkg::ST_NEGSC;
                    end else begin
                        n_y = m10y[W-1:0]; n_d = r_d - 6'd1;
                    end
                end else begin
                    n_state = sda_pkg::ST_ADDSUB;
                end
            end
            sda_pkg::ST_ADDSUB: begin
                if (r_nx == r_ny) begin
                    n_x = sum[W-1:0]; n_regovf = sum[W]; n_neg = r_nx;
                end else if (r_x >= r_y) begin
                    n_x = r_x - r_y; n_neg = r_nx;
                end else begin
                    n_x = r_y - r_x; n_neg = r_ny;
                end
                n_state = sda_pkg::ST_NEGSC;
            end
            sda_pkg::ST_MUL: begin
                n_x = macc[W-1:0];
                if (macc[W+1:W] != 2'd0) n_regovf = 1'b1;
                n_b = {r_b[62:0], 1'b0};
                n_k = r_k + 7'd1;
                if (r_k == 7'd63) n_state = sda_pkg::ST_NEGSC;
            end
            sda_pkg::ST_DIV: begin
                n_dr   = ge ? rsub[63:0] : rem2[63:0];
                n_dq   = {r_dq[W-2:0], ge};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == sda_pkg::DCNT_W'(W - 1)) n_state = r_ret;
            end
            sda_pkg::ST_DIV10: begin
                n_dr   = 64'(d10r);
                n_dq   = {r_dq[W-1-sda_pkg::D10_W:0], d10q};
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == sda_pkg::DCNT_W'(W / sda_pkg::D10_W - 1)) n_state = r_ret;
            end
            sda_pkg::ST_QUOT: begin
                n_x = W'(r_dq[63:0]); n_r = r_dr; n_cnt = 5'd0; n_k = 7'd0;
                n_state = sda_pkg::ST_DCOUNT;
            end
            sda_pkg::ST_DCOUNT: begin
                if (r_k[4:0] <= sda_pkg::POW_TOP && r_x[63:0] >= sda_pkg::pow10(r_k[4:0])) begin
                    n_cnt = r_cnt + 5'd1; n_k = r_k + 7'd1;
                end else if (r_cnt > qd) begin
                    n_sc = r_sc + 9'(qd) - 9'(r_cnt);
                    n_k = 7'(r_cnt - qd);
                    n_state = sda_pkg::ST_DTRUNC;
                end else begin
                    n_state = sda_pkg::ST_DSTEP;
                end
            end
            sda_pkg::ST_DTRUNC: begin
                if (r_k != 7'd0) begin
                    n_dq = r_x; n_dd = sda_pkg::TEN; n_dr = '0; n_dcnt = '0;
                    n_ret = sda_pkg::ST_DTRUNC_R; n_state = sda_pkg::ST_DIV10;
                end else begin
                    n_state = sda_pkg::ST_NEGSC;
                end
            end
            sda_pkg::ST_DTRUNC_R: begin
                n_x = r_dq; n_k = r_k - 7'd1; n_state = sda_pkg::ST_DTRUNC;
            end
            sda_pkg::ST_DSTEP: begin
                if (r_cnt < qd) begin
                    n_dq = m10r[W-1:0];
                    n_dd = r_b; n_dr = '0; n_dcnt = '0;
                    n_ret = sda_pkg::ST_DSTEP_R; n_state = sda_pkg::ST_DIV;
                end else begin
                    n_state = sda_pkg::ST_NEGSC;
                end
            end
            sda_pkg::ST_DSTEP_R: begin
                n_r = r_dr; n_x = xstep; n_sc = r_sc + 9'd1;
                if (xstep != '0) n_cnt = r_cnt + 5'd1;
                n_state = sda_pkg::ST_DSTEP;
            end
            sda_pkg::ST_NEGSC: begin
                if (r_regovf) begin
                    n_state = sda_pkg::ST_FINAL;
                end else if (r_sc[8]) begin
                    if (m10x[W+3:W] != 4'd0) begin
                        n_regovf = 1'b1; n_sc = 9'd0; n_state = sda_pkg::ST_FINAL;
                    end else begin
                        n_x = m10x[W-1:0]; n_sc = r_sc + 9'd1;
                    end
                end else begin
                    n_state = sda_pkg::ST_STRIP;
                end
            end
            sda_pkg::ST_STRIP: begin
                if (!r_sc[8] && r_sc != 9'd0 && r_x != '0) begin
                    n_dq = r_x; n_dd = sda_pkg::TEN; n_dr = '0; n_dcnt = '0;
                    n_ret = sda_pkg::ST_STRIP_R; n_state = sda_pkg::ST_DIV10;
                end else begin
                    if (r_x == '0) n_sc = 9'd0;
                    n_state = r_phase ? sda_pkg::ST_FINAL : sda_pkg::ST_CHK63;
                end
            end
            sda_pkg::ST_STRIP_R: begin
                if (r_dr == 64'd0) begin
                    n_x = r_dq; n_sc = r_sc - 9'd1; n_state = sda_pkg::ST_STRIP;
                end else begin
                    n_state = r_phase ? sda_pkg::ST_FINAL : sda_pkg::ST_CHK63;
                end
            end
            sda_pkg::ST_CHK63: begin
                if (!r_sc[8] && r_sc[7:6] != 2'd0) begin
                    n_ovf = 1'b1; n_state = sda_pkg::ST_TRUNC63;
                end else begin
                    n_state = sda_pkg::ST_FINAL;
                end
            end
            sda_pkg::ST_TRUNC63: begin
                if (!r_sc[8] && r_sc[7:6] != 2'd0) begin
                    n_dq = r_x; n_dd = sda_pkg::TEN; n_dr = '0; n_dcnt = '0;
                    n_ret = sda_pkg::ST_TRUNC63_R; n_state = sda_pkg::ST_DIV10;
                end else begin
                    n_phase = 1'b1; n_state = sda_pkg::ST_STRIP;
                end
            end
            sda_pkg::ST_TRUNC63_R: begin
                n_x = r_dq; n_sc = r_sc - 9'd1; n_state = sda_pkg::ST_TRUNC63;
            end
            sda_pkg::ST_FINAL: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov = 1'b1;
                    n_odz = r_dz;
                    if (r_dz) begin
                        n_om = 64'd0; n_os = 6'd0; n_oovf = 1'b0;
                    end else if (r_regovf) begin
                        n_om = r_neg ? sda_pkg::SAT_NEG : sda_pkg::SAT_POS;
                        n_os = r_sc[8] ? 6'd0 : ((r_sc[7:6] != 2'd0) ? 6'd63 : r_sc[5:0]);
                        n_oovf = 1'b1;
                    end else begin
                        n_om = big ? lim : (r_neg ? (64'd0 - r_x[63:0]) : r_x[63:0]);
                        n_os = r_sc[5:0];
                        n_oovf = r_ovf | big;
                    end
                    n_state = sda_pkg::ST_IDLE;
                end
            end
            default: n_state = sda_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sda_pkg::ST_IDLE;
            r_ret   <= sda_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_qd    <= sda_pkg::QD_RESET;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ov    <= n_ov;
            if (i_cfg_we) r_qd <= i_cfg_data;
        end
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b; r_r <= n_r;
        r_sa <= n_sa; r_sb <= n_sb; r_d <= n_d;
        r_na <= n_na; r_nb <= n_nb; r_nx <= n_nx; r_ny <= n_ny; r_neg <= n_neg;
        r_x <= n_x; r_y <= n_y; r_dq <= n_dq; r_sc <= n_sc;
        r_regovf <= n_regovf; r_ovf <= n_ovf; r_phase <= n_phase; r_dz <= n_dz;
        r_cnt <= n_cnt; r_k <= n_k; r_dd <= n_dd; r_dr <= n_dr; r_dcnt <= n_dcnt;
        r_oovf <= n_oovf; r_odz <= n_odz; r_om <= n_om; r_os <= n_os;
    end

endmodule

// ===== rtl/sda_checker.sv =====
module sda_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_mant,
    input logic [5:0]  i_scale,
    input logic        i_ovf,
    input logic        i_dz
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mant) && $stable(i_scale))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready straight after a transaction");

    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_dz |-> i_mant == 64'd0 && i_scale == 6'd0 && !i_ovf)
        else $error("divide by zero result not cleared");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ovf && i_mant == 64'd0 |-> i_scale == 6'd0)
        else $error("zero result not normalised");

endmodule

bind scaled_decimal_arithmetic_unit sda_props u_sda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_mant      (o_rsp.mantissa_out),
    .i_scale     (o_rsp.scale_out),
    .i_ovf       (o_rsp.overflow),
    .i_dz        (o_rsp.divide_by_zero)
);
